@@ rtl/core/cpl_pkg.sv @@
// ----------------------------------------------------------------------------
// cpl_pkg
// Shared types and constants for the clamped piecewise-linear calibration block.
// ----------------------------------------------------------------------------
package cpl_pkg;

  localparam int VAL_W  = 16;
  localparam int PIDX_W = 3;
  localparam int RES_W  = 14;
  localparam int DIFF_W = VAL_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int QUO_W  = DIFF_W;
  localparam int SUM_W  = QUO_W + 2;

  localparam logic [RES_W-1:0] PCT_MAX = RES_W'(10000);

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_SUM,
    ST_OUT
  } state_t;

endpackage

@@ rtl/core/clamped_piecewise_linear_calibration_top.sv @@
// ----------------------------------------------------------------------------
// clamped_piecewise_linear_calibration_top
// A point write is accepted from idle; a query runs a one-point-per-cycle scan of
// the curve store and, when it interpolates, a divider that retires two quotient
// bits per cycle. A query with no point below it or none above it skips the divider.
// One query is processed at a time. Synchronous reset clears all points to zero.
// ----------------------------------------------------------------------------
module clamped_piecewise_linear_calibration_top #(
  parameter int NUM_POINTS = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] point_index, [18:3] point_x, [34:19] point_y, [50:35] query_value
  input  logic [55:0] s_axis_tdata,
  // [0] req_type
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [13:0] calibrated
  output logic [15:0] m_axis_tdata
);

  localparam int IDX_W = $clog2(NUM_POINTS);
  localparam int VW    = cpl_pkg::VAL_W;

  cpl_pkg::state_t state, state_next;

  logic signed [VW-1:0] curve_x [NUM_POINTS];
  logic signed [VW-1:0] curve_y [NUM_POINTS];

  logic [cpl_pkg::PIDX_W-1:0] in_index;
  logic signed [VW-1:0]       in_x;
  logic signed [VW-1:0]       in_y;
  logic signed [VW-1:0]       in_value;
  logic [IDX_W+cpl_pkg::PIDX_W-1:0] wr_index;
  logic                        in_accept;

  logic [IDX_W-1:0]     cnt;
  logic signed [VW-1:0] qv;
  logic signed [VW-1:0] cx;
  logic signed [VW-1:0] cy;
  logic signed [VW-1:0] left_x, left_y, right_x, right_y, max_x, max_y;
  logic                 left_ok, right_ok, any_above, interp;
  logic                 below, above, scan_last, out_ready;

  logic signed [VW-1:0]              y0;
  logic signed [cpl_pkg::DIFF_W-1:0] dy, dv;
  logic signed [cpl_pkg::PROD_W-1:0] prod;
  logic [VW-1:0]                     den;
  logic [cpl_pkg::PROD_W-1:0]        prod_mag;
  logic [cpl_pkg::PROD_W-1:0]        div_quo;
  logic                              div_done;
  logic [cpl_pkg::QUO_W:0]           q_mag;
  logic signed [cpl_pkg::QUO_W:0]    q_signed;
  logic signed [cpl_pkg::SUM_W-1:0]  sum;
  logic [cpl_pkg::RES_W-1:0]         res;
  logic [cpl_pkg::RES_W-1:0]         out_data;
  logic                              out_valid;

  logic scan_en, pick_en, mul_en, div_start, sum_en, out_load;

  function automatic logic signed [cpl_pkg::DIFF_W-1:0] DIFF_W_CAST(
    input logic signed [cpl_pkg::VAL_W-1:0] v
  );
    return cpl_pkg::DIFF_W'(v);
  endfunction

  assign in_index  = s_axis_tdata[2:0];
  assign in_x      = s_axis_tdata[18:3];
  assign in_y      = s_axis_tdata[34:19];
  assign in_value  = s_axis_tdata[50:35];
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign wr_index  = {{IDX_W{1'b0}}, in_index};

  assign cx        = curve_x[cnt];
  assign cy        = curve_y[cnt];
  assign below     = cx < qv;
  assign above     = cx > qv;
  assign scan_last = cnt == IDX_W'(NUM_POINTS - 1);
  assign out_ready = !out_valid || m_axis_tready;

  assign dy       = DIFF_W_CAST(right_y) - DIFF_W_CAST(left_y);
  assign dv       = DIFF_W_CAST(qv) - DIFF_W_CAST(left_x);
  assign prod_mag = prod[cpl_pkg::PROD_W-1] ? unsigned'(-prod) : unsigned'(prod);
  assign q_mag    = {1'b0, div_quo[cpl_pkg::QUO_W-1:0]};
  assign q_signed = !interp ? '0 :
                    prod[cpl_pkg::PROD_W-1] ? -signed'(q_mag) : signed'(q_mag);
  assign sum      = cpl_pkg::SUM_W'(y0) + cpl_pkg::SUM_W'(q_signed);

  cpl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_mag),
    .divisor  (den),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_next = state;
    case (state)
      cpl_pkg::ST_IDLE: begin
        if (in_accept && s_axis_tuser == cpl_pkg::REQ_QUERY) begin
          state_next = cpl_pkg::ST_SCAN;
        end
      end
      cpl_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_next = cpl_pkg::ST_PICK;
        end
      end
      cpl_pkg::ST_PICK: begin
        if (left_ok && any_above) begin
          state_next = cpl_pkg::ST_MUL;
        end else begin
          state_next = cpl_pkg::ST_SUM;
        end
      end
      cpl_pkg::ST_MUL:  state_next = cpl_pkg::ST_LOAD;
      cpl_pkg::ST_LOAD: state_next = cpl_pkg::ST_DIV;
      cpl_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = cpl_pkg::ST_SUM;
        end
      end
      cpl_pkg::ST_SUM:  state_next = cpl_pkg::ST_OUT;
      cpl_pkg::ST_OUT: begin
        if (out_ready) begin
          state_next = cpl_pkg::ST_IDLE;
        end
      end
      default: state_next = cpl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    scan_en       = 1'b0;
    pick_en       = 1'b0;
    mul_en        = 1'b0;
    div_start     = 1'b0;
    sum_en        = 1'b0;
    out_load      = 1'b0;
    case (state)
      cpl_pkg::ST_IDLE: s_axis_tready = 1'b1;
      cpl_pkg::ST_SCAN: scan_en       = 1'b1;
      cpl_pkg::ST_PICK: pick_en       = 1'b1;
      cpl_pkg::ST_MUL:  mul_en        = 1'b1;
      cpl_pkg::ST_LOAD: div_start     = 1'b1;
      cpl_pkg::ST_SUM:  sum_en        = 1'b1;
      cpl_pkg::ST_OUT:  out_load      = out_ready;
      default: s_axis_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        curve_x[i] <= '0;
        curve_y[i] <= '0;
      end
    end else if (in_accept && s_axis_tuser == cpl_pkg::REQ_WRITE &&
                 wr_index < (IDX_W + cpl_pkg::PIDX_W)'(NUM_POINTS)) begin
      curve_x[wr_index[IDX_W-1:0]] <= in_x;
      curve_y[wr_index[IDX_W-1:0]] <= in_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_ok   <= 1'b0;
      right_ok  <= 1'b0;
      any_above <= 1'b0;
      interp    <= 1'b0;
      cnt       <= '0;
    end else if (in_accept) begin
      left_ok   <= 1'b0;
      right_ok  <= 1'b0;
      any_above <= 1'b0;
      interp    <= 1'b0;
      cnt       <= '0;
    end else if (scan_en) begin
      cnt <= IDX_W'(cnt + 1'b1);
      if (above) begin
        any_above <= 1'b1;
      end
      if (below && (!left_ok || cx >= left_x)) begin
        left_ok <= 1'b1;
      end
      if (!below && (!right_ok || cx < right_x)) begin
        right_ok <= 1'b1;
      end
    end else if (pick_en) begin
      interp <= left_ok && any_above;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      qv <= in_value;
    end
    if (scan_en) begin
      if (below && (!left_ok || cx >= left_x)) begin
        left_x <= cx;
        left_y <= cy;
      end
      if (!below && (!right_ok || cx < right_x)) begin
        right_x <= cx;
        right_y <= cy;
      end
      if (cnt == '0 || cx >= max_x) begin
        max_x <= cx;
        max_y <= cy;
      end
    end
    if (pick_en) begin
      if (!left_ok) begin
        y0 <= right_y;
      end else if (!any_above) begin
        y0 <= max_y;
      end else begin
        y0 <= left_y;
      end
    end
    if (mul_en) begin
      prod <= cpl_pkg::PROD_W'(dy) * cpl_pkg::PROD_W'(dv);
      den  <= VW'(right_x - left_x);
    end
    if (sum_en) begin
      if (sum < 0) begin
        res <= '0;
      end else if (sum > cpl_pkg::SUM_W'(cpl_pkg::PCT_MAX)) begin
        res <= cpl_pkg::PCT_MAX;
      end else begin
        res <= sum[cpl_pkg::RES_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_data};

endmodule

@@ rtl/core/cpl_div.sv @@
// ----------------------------------------------------------------------------
// cpl_div
// Unsigned restoring divider that retires two quotient bits per cycle.
// ----------------------------------------------------------------------------
module cpl_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [cpl_pkg::PROD_W-1:0]  dividend,
  input  logic [cpl_pkg::VAL_W-1:0]   divisor,
  output logic                        done,
  output logic [cpl_pkg::PROD_W-1:0]  quotient
);

  localparam int STEPS = cpl_pkg::PROD_W / 2;
  localparam int CNT_W = $clog2(STEPS);
  localparam int DW    = cpl_pkg::VAL_W;

  logic                        busy;
  logic [CNT_W-1:0]            cnt;
  logic [cpl_pkg::PROD_W-1:0]  quo;
  logic [cpl_pkg::PROD_W-1:0]  quo_next;
  logic [DW-1:0]               rem;
  logic [DW-1:0]               rem_mid;
  logic [DW-1:0]               rem_next;
  logic [DW-1:0]               den;
  logic [DW:0]                 trial1;
  logic [DW:0]                 trial2;
  logic                        bit1;
  logic                        bit2;

  always_comb begin
    trial1   = {rem, quo[cpl_pkg::PROD_W-1]};
    bit1     = trial1 >= {1'b0, den};
    rem_mid  = bit1 ? DW'(trial1 - {1'b0, den}) : trial1[DW-1:0];
    trial2   = {rem_mid, quo[cpl_pkg::PROD_W-2]};
    bit2     = trial2 >= {1'b0, den};
    rem_next = bit2 ? DW'(trial2 - {1'b0, den}) : trial2[DW-1:0];
    quo_next = {quo[cpl_pkg::PROD_W-3:0], bit1, bit2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= CNT_W'(cnt + 1'b1);
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule
